FILE: sv/ip_rule_longest_prefix_match_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the longest prefix match unit
// Both macros expand to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef IP_RULE_LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH
`define IP_RULE_LONGEST_PREFIX_MATCH_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define LPM_ASSERT_IMPL(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lpm assertion failed");
`define LPM_ASSERT_NEXT(label, clock, rst_n, ante, cons) \
	label: assert property (@(posedge clock) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lpm assertion failed");
`else
`define LPM_ASSERT_IMPL(label, clock, rst_n, ante, cons)
`define LPM_ASSERT_NEXT(label, clock, rst_n, ante, cons)
`endif

`endif

FILE: sv/lpm_pkg.sv
// ----------------------------------------------------------------------------
// Longest prefix match package
// Shared rule entry layout, scan control group, codes and prefix helper.
// ----------------------------------------------------------------------------
`default_nettype none

package lpm_pkg;

	localparam int SLOT_W   = 6;
	localparam int PREFIX_W = 8;
	localparam int ID_W     = 32;
	localparam int HALF_W   = 64;

	localparam logic [PREFIX_W-1:0] FULL_PREFIX = 8'd128;
	localparam logic [PREFIX_W-1:0] V4_PREFIX   = 8'd32;
	localparam logic [PREFIX_W-1:0] NO_PREFIX   = 8'd0;

	localparam logic CMD_WRITE  = 1'b0;
	localparam logic CMD_LOOKUP = 1'b1;
	localparam logic FAM_IPV6   = 1'b1;

	typedef struct packed {
		logic                valid;
		logic                family;
		logic [PREFIX_W-1:0] prefix;
		logic [HALF_W-1:0]   addr_hi;
		logic [HALF_W-1:0]   addr_lo;
		logic [ID_W-1:0]     id;
	} entry_t;

	typedef struct packed {
		logic clr;
		logic rd;
		logic last;
	} scan_ctl_t;

	function automatic logic [PREFIX_W-1:0] eff_prefix(
		input logic                has_prefix,
		input logic [PREFIX_W-1:0] prefix_given,
		input logic                is_single,
		input logic                family
	);
		logic [PREFIX_W-1:0] p;
		if (has_prefix) begin
			p = prefix_given;
		end else if (is_single) begin
			p = (family == FAM_IPV6) ? FULL_PREFIX : V4_PREFIX;
		end else begin
			p = NO_PREFIX;
		end
		if (p > FULL_PREFIX) begin
			p = FULL_PREFIX;
		end
		return p;
	endfunction

endpackage

`default_nettype wire

FILE: sv/lpm_table.sv
// ----------------------------------------------------------------------------
// Rule table memory
// Single write port and one read port with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_table #(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  lpm_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output lpm_pkg::entry_t rdata
);
	import lpm_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/lpm_match.sv
// ----------------------------------------------------------------------------
// Prefix compare and best rule selection
// Compares each table entry read against the client and keeps the best match.
// ----------------------------------------------------------------------------
`default_nettype none

module lpm_match #(
	parameter int AW = 6
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpm_pkg::scan_ctl_t            ctl,
	input  logic [AW-1:0]                 rd_slot,
	input  lpm_pkg::entry_t               entry,
	input  logic                          family,
	input  logic [lpm_pkg::HALF_W-1:0]    addr_hi,
	input  logic [lpm_pkg::HALF_W-1:0]    addr_lo,
	output logic                          done,
	output logic                          found,
	output logic [AW-1:0]                 best_slot,
	output logic [lpm_pkg::ID_W-1:0]      best_id,
	output logic [lpm_pkg::PREFIX_W-1:0]  best_len
);
	import lpm_pkg::*;

	logic                cli_fam_q;
	logic [2*HALF_W-1:0] cli_addr_q;

	logic                rd_s1;
	logic                last_s1;
	logic [AW-1:0]       slot_s1;

	logic                hit_s2;
	logic                last_s2;
	logic [AW-1:0]       slot_s2;
	logic [PREFIX_W-1:0] pre_s2;
	logic [ID_W-1:0]     id_s2;

	logic                bfound_q;
	logic [AW-1:0]       bslot_q;
	logic [ID_W-1:0]     bid_q;
	logic [PREFIX_W-1:0] bpre_q;

	logic                done_q;

	logic [2*HALF_W-1:0] mask_c;
	logic [2*HALF_W-1:0] diff_c;
	logic                hit_c;
	logic                better_c;

	assign mask_c = ~({(2*HALF_W){1'b1}} >> entry.prefix);
	assign diff_c = cli_addr_q ^ {entry.addr_hi, entry.addr_lo};
	assign hit_c  = rd_s1 && entry.valid && (entry.family == cli_fam_q) &&
	                ((diff_c & mask_c) == '0);

	assign better_c = hit_s2 && (!bfound_q || (pre_s2 > bpre_q) ||
	                  ((pre_s2 == bpre_q) && (id_s2 < bid_q)));

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			cli_fam_q  <= family;
			cli_addr_q <= {addr_hi, addr_lo};
		end
		slot_s1 <= rd_slot;
		slot_s2 <= slot_s1;
		pre_s2  <= entry.prefix;
		id_s2   <= entry.id;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_s1    <= 1'b0;
			last_s1  <= 1'b0;
			hit_s2   <= 1'b0;
			last_s2  <= 1'b0;
			bfound_q <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			rd_s1   <= ctl.rd;
			last_s1 <= ctl.rd && ctl.last;
			hit_s2  <= hit_c;
			last_s2 <= last_s1;
			done_q  <= last_s2;
			if (ctl.clr) begin
				bfound_q <= 1'b0;
			end else if (better_c) begin
				bfound_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			bslot_q <= '0;
			bid_q   <= '0;
			bpre_q  <= '0;
		end else if (better_c) begin
			bslot_q <= slot_s2;
			bid_q   <= id_s2;
			bpre_q  <= pre_s2;
		end
		if (last_s2) begin
			found     <= better_c || bfound_q;
			best_slot <= better_c ? slot_s2 : bslot_q;
			best_id   <= better_c ? id_s2 : bid_q;
			best_len  <= better_c ? pre_s2 : bpre_q;
		end
	end

	assign done = done_q;

endmodule

`default_nettype wire

FILE: sv/ip_rule_longest_prefix_match_unit.sv
// ----------------------------------------------------------------------------
// IP rule longest prefix match unit: a write is taken while idle, back to back.
// A lookup reads one entry per cycle; done pulses once the last entry has passed
// the table read register, the hit register and the done register, and busy drops
// in the cycle after done, so the next lookup is taken only then. Results cannot be
// stalled by the receiver. After reset, busy stays high while the table clears.
// ----------------------------------------------------------------------------
`default_nettype none
`include "ip_rule_longest_prefix_match_unit_defines.svh"

module ip_rule_longest_prefix_match_unit #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [lpm_pkg::SLOT_W-1:0]    slot,
	input  logic                          entry_valid,
	input  logic                          family,
	input  logic                          has_prefix,
	input  logic [lpm_pkg::PREFIX_W-1:0]  prefix_given,
	input  logic                          is_single,
	input  logic [lpm_pkg::HALF_W-1:0]    addr_hi,
	input  logic [lpm_pkg::HALF_W-1:0]    addr_lo,
	input  logic [lpm_pkg::ID_W-1:0]      rule_id,
	output logic                          done,
	output logic                          found,
	output logic [lpm_pkg::SLOT_W-1:0]    best_slot,
	output logic [lpm_pkg::ID_W-1:0]      best_id,
	output logic [lpm_pkg::PREFIX_W-1:0]  best_len
);
	import lpm_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_DEPTH - 1);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] cnt_q;

	logic          accept;
	logic          wr_cmd;
	logic          clearing;
	logic          tbl_we;
	logic [AW-1:0] tbl_waddr;
	entry_t        tbl_wdata;
	entry_t        new_entry;
	entry_t        tbl_rdata;
	scan_ctl_t     ctl;
	logic [AW-1:0] m_best_slot;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign clearing = (state_q == ST_CLEAR);
	assign wr_cmd   = accept && (command == CMD_WRITE) && (32'(slot) < TABLE_DEPTH);

	always_comb begin
		new_entry.valid   = entry_valid;
		new_entry.family  = family;
		new_entry.prefix  = eff_prefix(has_prefix, prefix_given, is_single, family);
		new_entry.addr_hi = addr_hi;
		new_entry.addr_lo = addr_lo;
		new_entry.id      = rule_id;
	end

	assign tbl_we    = clearing || wr_cmd;
	assign tbl_waddr = clearing ? cnt_q : AW'(slot);
	assign tbl_wdata = clearing ? '0 : new_entry;

	assign ctl.clr  = accept && (command == CMD_LOOKUP);
	assign ctl.rd   = (state_q == ST_SCAN);
	assign ctl.last = (cnt_q == LAST_IDX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (ctl.clr) begin
						cnt_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (cnt_q == LAST_IDX) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_CLEAR;
					cnt_q   <= '0;
				end
			endcase
		end
	end

	lpm_table #(
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_table (
		.clk   (clk),
		.we    (tbl_we),
		.waddr (tbl_waddr),
		.wdata (tbl_wdata),
		.re    (ctl.rd),
		.raddr (cnt_q),
		.rdata (tbl_rdata)
	);

	lpm_match #(
		.AW (AW)
	) u_match (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.rd_slot   (cnt_q),
		.entry     (tbl_rdata),
		.family    (family),
		.addr_hi   (addr_hi),
		.addr_lo   (addr_lo),
		.done      (done),
		.found     (found),
		.best_slot (m_best_slot),
		.best_id   (best_id),
		.best_len  (best_len)
	);

	assign best_slot = SLOT_W'(m_best_slot);

	`LPM_ASSERT_IMPL(a_done_in_drain, clk, arst_n, done, state_q == ST_DRAIN)
	`LPM_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`LPM_ASSERT_IMPL(a_miss_zero, clk, arst_n, done && !found, ({best_slot, best_id, best_len} == '0))
	`LPM_ASSERT_NEXT(a_lookup_scans, clk, arst_n, ctl.clr, state_q == ST_SCAN)

endmodule

`default_nettype wire
